// ===== rtl/midi_running_status_parser_fifo_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros shared by the midi parser rtl
// ---------------------------------------------------------------------------
`ifndef MIDI_RUNNING_STATUS_PARSER_FIFO_MACROS_SVH
`define MIDI_RUNNING_STATUS_PARSER_FIFO_MACROS_SVH

// implication checked on every clock edge outside of reset
`define MRSP_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (lhs) |-> (rhs)) \
    else $error(msg);

// plain invariant checked on every clock edge outside of reset
`define MRSP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

`endif

// ===== rtl/mrsp_pkg.sv =====
// ---------------------------------------------------------------------------
// mrsp_pkg
// types, midi byte codes and decode helpers for the running status parser
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrsp_pkg;

  typedef enum logic [1:0] {
    OP_FEED  = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2
  } mrsp_op_e;

  localparam logic [7:0] MIDI_SYSEX_START  = 8'hF0;
  localparam logic [7:0] MIDI_SYSCOM_FIRST = 8'hF1;
  localparam logic [7:0] MIDI_SYSEX_END    = 8'hF7;
  localparam logic [7:0] MIDI_RT_FIRST     = 8'hF8;

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_PROGRAM  = 4'hC;
  localparam logic [3:0] KIND_PRESSURE = 4'hD;
  localparam logic [3:0] KIND_PITCH    = 4'hE;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
  } mrsp_event_t;

  // number of data bytes a channel status byte expects
  function automatic logic [1:0] data_count(logic [7:0] status);
    logic [3:0] kind;
    kind = status[7:4];
    if (kind == KIND_PROGRAM || kind == KIND_PRESSURE) begin
      return 2'd1;
    end else if (kind >= KIND_NOTE_OFF && kind <= KIND_PITCH) begin
      return 2'd2;
    end
    return 2'd0;
  endfunction

endpackage

// ===== rtl/midi_running_status_parser_fifo.sv =====
// ---------------------------------------------------------------------------
// midi_running_status_parser_fifo
// parses raw midi bytes with running status into channel messages and queues
// them in an event fifo that drops its oldest entry when full
// ---------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o  | operation_i, byte_in_i
//  out     | out_valid_o / out_stall_i| event_valid_o, event_status_o,
//          |                          | event_data1_o, event_data2_o,
//          |                          | events_left_o
//
// one word per cycle when not stalled; a word is decoded in the cycle after
// it is taken, or once the stall ends for a read word; read results are
// registered; reset clears the parser and fifo pointers, not event memory;
// only a read word waiting on a full, stalled result register holds the input
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "midi_running_status_parser_fifo_macros.svh"

module midi_running_status_parser_fifo #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       event_valid_o,
  output logic [7:0] event_status_o,
  output logic [6:0] event_data1_o,
  output logic [6:0] event_data2_o,
  output logic [6:0] events_left_o
);
  import mrsp_pkg::*;

  localparam int PtrW = $clog2(FIFO_DEPTH);
  localparam int CntW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

  // input register
  logic       in_vld_q;
  mrsp_op_e   in_op_q;
  logic [7:0] in_byte_q;

  // fifo control
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_dec;
  logic [CntW+6:0] left_ext;
  logic            cnt_empty_full;

  // parser state
  logic [7:0] rs_q, rs_d;
  logic [1:0] need_q, need_d;
  logic [6:0] first_q, first_d;
  logic       sysex_q, sysex_d;

  // result register
  logic        out_vld_q, out_vld_d;
  logic        out_hit_q, out_hit_d;
  logic [6:0]  out_left_q, out_left_d;
  mrsp_event_t rd_data_q;

  logic        mem_we, mem_re, exec_go, is_read;
  mrsp_event_t push_ev;
  mrsp_event_t mem_q [FIFO_DEPTH];

  assign is_read    = (in_op_q == OP_READ);
  assign exec_go    = in_vld_q && (!is_read || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !exec_go;
  assign cnt_dec    = cnt_q - 1'b1;
  assign left_ext   = {7'd0, cnt_dec};
  assign cnt_empty_full = (cnt_q == '0) || (cnt_q == CntFull);

  always_comb begin
    logic [1:0] need_eff;
    logic [1:0] rs_count;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    cnt_d      = cnt_q;
    rs_d       = rs_q;
    need_d     = need_q;
    first_d    = first_q;
    sysex_d    = sysex_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    push_ev    = '0;
    out_hit_d  = out_hit_q;
    out_left_d = out_left_q;
    out_vld_d  = out_vld_q && out_stall_i;
    rs_count   = data_count(rs_q);
    need_eff   = (need_q == 2'd0) ? rs_count : need_q;

    if (exec_go) begin
      case (in_op_q)
        OP_FEED: begin
          if (sysex_q) begin
            if (in_byte_q == MIDI_SYSEX_END) begin
              sysex_d = 1'b0;
            end
          end else if (in_byte_q >= MIDI_RT_FIRST) begin
            // realtime bytes pass through the parser untouched
          end else if (in_byte_q == MIDI_SYSEX_START) begin
            sysex_d = 1'b1;
            need_d  = 2'd0;
          end else if (in_byte_q >= MIDI_SYSCOM_FIRST) begin
            need_d = 2'd0;
          end else if (in_byte_q[7]) begin
            rs_d    = in_byte_q;
            need_d  = data_count(in_byte_q);
            first_d = '0;
          end else if (need_eff == 2'd2) begin
            first_d = in_byte_q[6:0];
            need_d  = 2'd1;
          end else if (need_eff == 2'd1) begin
            need_d         = 2'd0;
            mem_we         = 1'b1;
            push_ev.status = rs_q;
            if (rs_count == 2'd1) begin
              push_ev.data1 = in_byte_q[6:0];
              push_ev.data2 = '0;
            end else begin
              push_ev.data1 = first_q;
              push_ev.data2 = in_byte_q[6:0];
            end
            // note-on with zero velocity is a note-off
            if (rs_q[7:4] == KIND_NOTE_ON && push_ev.data2 == 7'd0) begin
              push_ev.status = {KIND_NOTE_OFF, rs_q[3:0]};
            end
            wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
            if (cnt_q == CntFull) begin
              rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
        end
        OP_READ: begin
          out_vld_d = 1'b1;
          if (cnt_q != '0) begin
            mem_re     = 1'b1;
            out_hit_d  = 1'b1;
            out_left_d = left_ext[6:0];
            rd_ptr_d   = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
            cnt_d      = cnt_dec;
          end else begin
            out_hit_d  = 1'b0;
            out_left_d = '0;
          end
        end
        OP_FLUSH: begin
          wr_ptr_d = '0;
          rd_ptr_d = '0;
          cnt_d    = '0;
          rs_d     = '0;
          need_d   = '0;
          first_d  = '0;
          sysex_d  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      in_op_q    <= OP_FEED;
      in_byte_q  <= '0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      rs_q       <= '0;
      need_q     <= '0;
      first_q    <= '0;
      sysex_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      out_hit_q  <= 1'b0;
      out_left_q <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q  <= 1'b1;
        in_op_q   <= mrsp_op_e'(operation_i);
        in_byte_q <= byte_in_i;
      end else if (exec_go) begin
        in_vld_q <= 1'b0;
      end
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      cnt_q      <= cnt_d;
      rs_q       <= rs_d;
      need_q     <= need_d;
      first_q    <= first_d;
      sysex_q    <= sysex_d;
      out_vld_q  <= out_vld_d;
      out_hit_q  <= out_hit_d;
      out_left_q <= out_left_d;
    end
  end

  // event memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= push_ev;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign event_valid_o  = out_hit_q;
  assign event_status_o = out_hit_q ? rd_data_q.status : '0;
  assign event_data1_o  = out_hit_q ? rd_data_q.data1 : '0;
  assign event_data2_o  = out_hit_q ? rd_data_q.data2 : '0;
  assign events_left_o  = out_left_q;

  `MRSP_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CntFull, "event count above fifo depth")
  `MRSP_ASSERT_IMPL(a_ptr_match, wr_ptr_q == rd_ptr_q, cnt_empty_full, "pointers meet mid fill")
  `MRSP_ASSERT_IMPL(a_stall, in_stall_o, is_read && out_vld_q && out_stall_i, "stray stall")
  `MRSP_ASSERT_IMPL(a_empty_left, out_vld_q && !out_hit_q, out_left_q == '0, "left set on miss")

endmodule

// ===== sim/tb_midi_running_status_parser_fifo.sv =====
// ---------------------------------------------------------------------------
// tb_midi_running_status_parser_fifo
// feeds midi byte streams, reads and flushes into the parser fifo. every read
// result is compared with a local model of the parser and queue, or a set value.
// a short directed list comes first, then random traffic built mostly from
// well-formed messages, with random stalls on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_midi_running_status_parser_fifo;
  import mrsp_pkg::*;

  localparam int EVENT_DEPTH   = 64;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  localparam logic [1:0] OP_UNUSED          = 2'd3;
  localparam logic [3:0] KIND_POLY_PRESSURE = 4'hA;
  localparam logic [3:0] KIND_CONTROL       = 4'hB;

  typedef struct packed {
    logic        valid;
    mrsp_event_t ev;
    logic [6:0]  left;
  } read_result_t;

  typedef struct packed {
    logic [1:0]   op;
    logic [7:0]   data;
    logic         typed;
    read_result_t want;
  } stim_word_t;

  localparam read_result_t NO_EVENT   = '0;
  localparam read_result_t FIRST_NOTE = '{1'b1, '{8'h90, 7'h00, 7'h7f}, 7'd4};

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] operation_i;
  logic [7:0] byte_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       event_valid_o;
  logic [7:0] event_status_o;
  logic [6:0] event_data1_o;
  logic [6:0] event_data2_o;
  logic [6:0] events_left_o;

  midi_running_status_parser_fifo #(
    .FIFO_DEPTH(EVENT_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .byte_in_i     (byte_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_valid_o (event_valid_o),
    .event_status_o(event_status_o),
    .event_data1_o (event_data1_o),
    .event_data2_o (event_data2_o),
    .events_left_o (events_left_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model of the parser and event queue
  mrsp_event_t ev_mem [EVENT_DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;
  int unsigned ev_count;
  logic [7:0]  last_status;
  int unsigned data_pending;
  logic [6:0]  held_data1;
  bit          sysex_skip;

  read_result_t pending_reads [$];
  stim_word_t   directed_words [27];
  logic [3:0]   kind_pool [7] = '{KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRESSURE,
                                  KIND_CONTROL, KIND_PROGRAM, KIND_PRESSURE, KIND_PITCH};

  int  mismatches;
  int  words_sent;
  int  idle_pct;
  int  read_pct;
  bit  flush_ok;
  bit  hold_req;

  function automatic int msg_length(logic [7:0] st);
    case (st[7:4])
      KIND_PROGRAM, KIND_PRESSURE: return 1;
      KIND_NOTE_OFF, KIND_NOTE_ON, KIND_POLY_PRESSURE, KIND_CONTROL, KIND_PITCH: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic void clear_model();
    wr_ptr       = 0;
    rd_ptr       = 0;
    ev_count     = 0;
    last_status  = '0;
    data_pending = 0;
    held_data1   = '0;
    sysex_skip   = 1'b0;
  endfunction

  function automatic void queue_event(mrsp_event_t ev);
    // full queue loses its oldest event
    if (ev_count >= EVENT_DEPTH) begin
      rd_ptr = (rd_ptr + 1) % EVENT_DEPTH;
      ev_count--;
    end
    ev_mem[wr_ptr] = ev;
    wr_ptr = (wr_ptr + 1) % EVENT_DEPTH;
    ev_count++;
  endfunction

  function automatic void parse_midi_byte(logic [7:0] b);
    mrsp_event_t ev;
    if (sysex_skip) begin
      if (b == MIDI_SYSEX_END) sysex_skip = 1'b0;
      return;
    end
    if (b >= MIDI_RT_FIRST) return;
    if (b == MIDI_SYSEX_START) begin
      sysex_skip = 1'b1;
      data_pending = 0;
      return;
    end
    if (b >= MIDI_SYSCOM_FIRST) begin
      data_pending = 0;
      return;
    end
    if (b[7]) begin
      last_status = b;
      data_pending = msg_length(b);
      held_data1 = '0;
      return;
    end
    if (data_pending == 0) begin
      data_pending = msg_length(last_status);
      if (data_pending == 0) return;
    end
    if (data_pending == 2) begin
      held_data1 = b[6:0];
      data_pending = 1;
      return;
    end
    ev.status = last_status;
    if (msg_length(last_status) == 1) begin
      ev.data1 = b[6:0];
      ev.data2 = '0;
    end else begin
      ev.data1 = held_data1;
      ev.data2 = b[6:0];
    end
    data_pending = 0;
    // note-on with zero velocity goes out as note-off
    if (ev.status[7:4] == KIND_NOTE_ON && ev.data2 == '0) begin
      ev.status = {KIND_NOTE_OFF, ev.status[3:0]};
    end
    queue_event(ev);
  endfunction

  function automatic bit predict_word(logic [1:0] op, logic [7:0] b, output read_result_t r);
    r = NO_EVENT;
    case (op)
      OP_FEED: begin
        parse_midi_byte(b);
        return 1'b0;
      end
      OP_FLUSH: begin
        clear_model();
        return 1'b0;
      end
      OP_READ: begin
        if (ev_count != 0) begin
          r.valid = 1'b1;
          r.ev = ev_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % EVENT_DEPTH;
          ev_count--;
          r.left = ev_count[6:0];
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void flag_error(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endfunction

  // one word through the input handshake, called at a falling edge
  task automatic send_word(logic [1:0] op, logic [7:0] b, logic typed = 1'b0,
                           read_result_t want = NO_EVENT);
    read_result_t r;
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    operation_i = op;
    byte_in_i   = b;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_word(op, b, r)) pending_reads.push_back(typed ? want : r);
    words_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic maybe_read();
    if ($urandom_range(0, 99) < read_pct) send_word(OP_READ, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_message();
    logic [7:0] st;
    logic [6:0] d;
    int len;
    st = {kind_pool[$urandom_range(0, 6)], 4'($urandom_range(0, 15))};
    // lean on running status about half the time
    if (last_status != '0 && $urandom_range(0, 1) == 1) begin
      st = last_status;
    end else begin
      send_word(OP_FEED, st);
    end
    len = msg_length(st);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_word(OP_FEED, 8'(MIDI_RT_FIRST + $urandom_range(0, 7)));
      maybe_read();
      d = 7'($urandom_range(0, 127));
      if (i == len - 1 && st[7:4] == KIND_NOTE_ON && $urandom_range(0, 3) == 0) d = '0;
      send_word(OP_FEED, {1'b0, d});
    end
  endtask

  task automatic random_activity();
    int pick;
    maybe_read();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_message();
    end else if (pick < 78) begin
      send_word(OP_FEED, MIDI_SYSEX_START);
      repeat ($urandom_range(0, 6)) send_word(OP_FEED, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) != 0) send_word(OP_FEED, MIDI_SYSEX_END);
    end else if (pick < 83) begin
      send_word(OP_FEED, 8'($urandom_range(MIDI_SYSCOM_FIRST, MIDI_SYSEX_END)));
    end else if (pick < 87) begin
      send_word(OP_FEED, 8'($urandom_range(MIDI_RT_FIRST, 8'hff)));
    end else if (pick < 91) begin
      // message cut short by whatever follows
      send_word(OP_FEED, 8'($urandom_range(8'h80, 8'hef)));
      if ($urandom_range(0, 1) == 1) send_word(OP_FEED, 8'($urandom_range(0, 127)));
    end else if (pick < 95) begin
      send_word(OP_FEED, 8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      send_word(OP_UNUSED, 8'($urandom_range(0, 255)));
    end else if (pick < 98 && flush_ok) begin
      send_word(OP_FLUSH, 8'($urandom_range(0, 255)));
    end else begin
      send_word(OP_READ, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(int target);
    while (words_sent < target) random_activity();
  endtask

  task automatic wait_drained();
    while (pending_reads.size() != 0) @(negedge clk_i);
  endtask

  // result side stalls
  initial begin : result_side
    int stall_left;
    out_stall_i = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 1'b0;
      end else begin
        if (stall_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
          stall_left = $urandom_range(1, 15);
        end
        out_stall_i = (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    read_result_t got;
    read_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{event_valid_o, '{event_status_o, event_data1_o, event_data2_o}, events_left_o};
      if (pending_reads.size() == 0) begin
        flag_error($sformatf("read result with none pending: %h", got));
      end else begin
        want = pending_reads.pop_front();
        if (got.valid !== want.valid || got.ev.status !== want.ev.status ||
            got.ev.data1 !== want.ev.data1 || got.ev.data2 !== want.ev.data2 ||
            got.left !== want.left) begin
          flag_error($sformatf({"read mismatch: expected valid %0d status %h d1 %h d2 %h ",
                                "left %0d, got valid %0d status %h d1 %h d2 %h left %0d"},
                               want.valid, want.ev.status, want.ev.data1, want.ev.data2,
                               want.left, got.valid, got.ev.status, got.ev.data1,
                               got.ev.data2, got.left));
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_midi_running_status_parser_fifo failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OP_FEED;
    byte_in_i   = '0;
    mismatches  = 0;
    words_sent  = 0;
    idle_pct    = 0;
    read_pct    = 0;
    flush_ok    = 1'b1;
    hold_req    = 1'b0;
    clear_model();

    directed_words = '{
      '{OP_READ,   8'h00, 1'b1, NO_EVENT},   // empty queue after reset
      '{OP_FEED,   8'h40, 1'b0, NO_EVENT},   // data with no running status
      '{OP_FEED,   8'h90, 1'b0, NO_EVENT},
      '{OP_FEED,   8'h00, 1'b0, NO_EVENT},
      '{OP_FEED,   8'h7f, 1'b0, NO_EVENT},
      '{OP_FEED,   8'h7f, 1'b0, NO_EVENT},   // running status note-on
      '{OP_FEED,   8'h00, 1'b0, NO_EVENT},   // zero velocity
      '{OP_FEED,   8'hc5, 1'b0, NO_EVENT},
      '{OP_FEED,   8'hf8, 1'b0, NO_EVENT},   // realtime inside a message
      '{OP_FEED,   8'h7f, 1'b0, NO_EVENT},
      '{OP_FEED,   8'hf0, 1'b0, NO_EVENT},
      '{OP_FEED,   8'h90, 1'b0, NO_EVENT},   // swallowed by sysex
      '{OP_FEED,   8'hf7, 1'b0, NO_EVENT},
      '{OP_FEED,   8'hf3, 1'b0, NO_EVENT},
      '{OP_FEED,   8'h00, 1'b0, NO_EVENT},   // running status survives system bytes
      '{OP_FEED,   8'hef, 1'b0, NO_EVENT},
      '{OP_FEED,   8'h12, 1'b0, NO_EVENT},
      '{OP_FEED,   8'hf6, 1'b0, NO_EVENT},   // system common drops the half message
      '{OP_FEED,   8'h34, 1'b0, NO_EVENT},
      '{OP_FEED,   8'h56, 1'b0, NO_EVENT},
      '{OP_UNUSED, 8'hff, 1'b0, NO_EVENT},
      '{OP_READ,   8'hff, 1'b1, FIRST_NOTE},
      '{OP_FEED,   8'hdf, 1'b0, NO_EVENT},
      '{OP_FEED,   8'h55, 1'b0, NO_EVENT},
      '{OP_FLUSH,  8'h00, 1'b0, NO_EVENT},
      '{OP_READ,   8'h80, 1'b1, NO_EVENT},   // empty again after flush
      '{OP_FEED,   8'hff, 1'b0, NO_EVENT}
    };

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_words[i]) begin
      send_word(directed_words[i].op, directed_words[i].data, directed_words[i].typed,
                directed_words[i].want);
    end
    wait_drained();

    idle_pct = 12;
    read_pct = 25;
    run_random(300);

    // long receiver hold while reads keep coming, input has to back up
    idle_pct = 0;
    hold_req = 1'b1;
    repeat (40) send_word(OP_READ, 8'($urandom_range(0, 255)));
    wait_drained();

    // mostly feeds so the queue overflows
    idle_pct = 8;
    read_pct = 2;
    flush_ok = 1'b0;
    run_random(560);

    // mostly reads, drains into empty reads
    idle_pct = 15;
    read_pct = 70;
    flush_ok = 1'b1;
    run_random(780);
    wait_drained();

    idle_pct = 0;
    read_pct = 30;
    run_random(1080);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("tb_midi_running_status_parser_fifo passed");
    end else begin
      $display("tb_midi_running_status_parser_fifo failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mrsp_pkg.sv
rtl/midi_running_status_parser_fifo.sv
sim/tb_midi_running_status_parser_fifo.sv
